@@ hdl/bspline_basis_eval_core_defines.svh @@
// Assertion macros shared by the checker of the B-spline basis evaluator.
// Depends on i_clk and i_rst_n being visible where the macros are used.
`ifndef BSPLINE_BASIS_EVAL_CORE_DEFINES_SVH
`define BSPLINE_BASIS_EVAL_CORE_DEFINES_SVH

// antecedent in one cycle, consequent in the next
`define BBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent and consequent in the same cycle
`define BBE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/bbe_pkg.sv @@
// Shared types, constants and the knot clamp function of the basis evaluator.
// No dependencies.
`default_nettype none

package bbe_pkg;

    localparam int CFG_W  = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd3;
    localparam int IDX_W  = 6;
    localparam int SPAN_W = 7;
    localparam int KX_W   = 9;
    localparam int M_W    = 3;

    typedef struct packed {
        logic is_zero;
        logic is_one;
    } t_flags;

    // clamped uniform knot position in whole spans
    function automatic logic [SPAN_W-1:0] knot_pos(input logic signed [KX_W-1:0] x,
                                                   input logic [SPAN_W-1:0] spans);
        if (x < 0) begin
            return '0;
        end else if (x > $signed({2'b00, spans})) begin
            return spans;
        end else begin
            return x[SPAN_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/bbe_round.sv @@
// One Cox-de Boor recurrence level over all DEGREE+1 slots, three register stages.
// Depends on bbe_pkg.
`default_nettype none

module bbe_round #(
    parameter int DEGREE        = 3,
    parameter int FRACTION_BITS = 16,
    parameter int ROUND         = 1
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic [bbe_pkg::SPAN_W-1:0]            i_spans,
    input  wire logic                                  i_valid,
    input  wire logic [FRACTION_BITS+bbe_pkg::SPAN_W-1:0] i_us,
    input  wire bbe_pkg::t_flags                       i_flags,
    input  wire logic [DEGREE:0][FRACTION_BITS:0]      i_w,
    output logic                                       o_valid,
    output logic [FRACTION_BITS+bbe_pkg::SPAN_W-1:0]   o_us,
    output bbe_pkg::t_flags                            o_flags,
    output logic [DEGREE:0][FRACTION_BITS:0]           o_w
);
    import bbe_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int UW    = F + SPAN_W;
    localparam int NUM_W = F + 3;
    localparam int WW    = F + 1;
    localparam int XW    = NUM_W + WW;
    localparam int SW    = XW + 1;
    localparam int YW    = F + 5;
    localparam int P     = YW + 3;
    localparam int RW    = P + 1;
    localparam int PW    = YW + RW;
    localparam logic [63:0] ONE_P = 64'd1 << P;
    // ceil(2^P / m); exact quotient for every Y below 2^YW and m up to 7
    localparam logic [RW-1:0] RECIP [8] = '{
        RW'(0), RW'(ONE_P), RW'((ONE_P + 1) / 2), RW'((ONE_P + 2) / 3),
        RW'((ONE_P + 3) / 4), RW'((ONE_P + 4) / 5), RW'((ONE_P + 5) / 6),
        RW'((ONE_P + 6) / 7)
    };
    localparam logic [WW-1:0] ONE = {1'b1, {F{1'b0}}};

    logic [SPAN_W-1:0] span_idx;
    logic [SPAN_W-1:0] k_i   [DEGREE+1];
    logic [SPAN_W-1:0] k_i1  [DEGREE+1];
    logic [SPAN_W-1:0] k_id  [DEGREE+1];
    logic [SPAN_W-1:0] k_id1 [DEGREE+1];
    logic [UW-1:0]     a_full [DEGREE+1];
    logic [UW-1:0]     b_full [DEGREE+1];
    logic [SPAN_W-1:0] a_mf [DEGREE+1];
    logic [SPAN_W-1:0] b_mf [DEGREE+1];
    logic [WW-1:0]     w_b  [DEGREE+1];

    logic [XW-1:0]  r_xa [DEGREE+1];
    logic [XW-1:0]  r_xb [DEGREE+1];
    logic [M_W-1:0] r_ma [DEGREE+1];
    logic [M_W-1:0] r_mb [DEGREE+1];
    logic [PW-1:0]  r_pa [DEGREE+1];
    logic [PW-1:0]  r_pb [DEGREE+1];
    logic [SW-1:0]  ya_s [DEGREE+1];
    logic [SW-1:0]  yb_s [DEGREE+1];
    logic [YW:0]    sum_ab [DEGREE+1];

    logic           r_va, r_vb, r_vc;
    logic [UW-1:0]  r_usa, r_usb, r_usc;
    t_flags         r_fa, r_fb, r_fc;
    logic [DEGREE:0][WW-1:0] r_w;

    assign span_idx = i_us[UW-1:F];

    // stage A: knot distances, products num * w
    always_comb begin
        for (int i = 0; i <= DEGREE; i++) begin
            k_i[i]   = knot_pos($signed({2'b00, span_idx}) + $signed(KX_W'(i - DEGREE)),
                                i_spans);
            k_i1[i]  = knot_pos($signed({2'b00, span_idx}) + $signed(KX_W'(i + 1 - DEGREE)),
                                i_spans);
            k_id[i]  = knot_pos($signed({2'b00, span_idx}) +
                                $signed(KX_W'(i + ROUND - DEGREE)), i_spans);
            k_id1[i] = knot_pos($signed({2'b00, span_idx}) +
                                $signed(KX_W'(i + ROUND + 1 - DEGREE)), i_spans);
            a_full[i] = (i_us > {k_i[i], {F{1'b0}}}) ? (i_us - {k_i[i], {F{1'b0}}}) : '0;
            b_full[i] = ({k_id1[i], {F{1'b0}}} > i_us) ? ({k_id1[i], {F{1'b0}}} - i_us) : '0;
            a_mf[i] = k_id[i] - k_i[i];
            b_mf[i] = k_id1[i] - k_i1[i];
            w_b[i]  = (i == DEGREE) ? '0 : i_w[(i + 1) % (DEGREE + 1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= DEGREE; i++) begin
                r_xa[i] <= a_full[i][NUM_W-1:0] * i_w[i];
                r_xb[i] <= b_full[i][NUM_W-1:0] * w_b[i];
                r_ma[i] <= a_mf[i][M_W-1:0];
                r_mb[i] <= b_mf[i][M_W-1:0];
            end
            r_usa <= i_us;
            r_fa  <= i_flags;
        end
    end

    // stage B: round half up, divide by m * 2^F through reciprocal
    always_comb begin
        for (int i = 0; i <= DEGREE; i++) begin
            ya_s[i] = {1'b0, r_xa[i]} + (SW'(r_ma[i]) << (F - 1));
            yb_s[i] = {1'b0, r_xb[i]} + (SW'(r_mb[i]) << (F - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= DEGREE; i++) begin
                r_pa[i] <= ya_s[i][SW-1:F] * RECIP[r_ma[i]];
                r_pb[i] <= yb_s[i][SW-1:F] * RECIP[r_mb[i]];
            end
            r_usb <= r_usa;
            r_fb  <= r_fa;
        end
    end

    // stage C: quotients, sum, saturate to 1.0
    always_comb begin
        for (int i = 0; i <= DEGREE; i++) begin
            sum_ab[i] = {1'b0, r_pa[i][P+YW-1:P]} + {1'b0, r_pb[i][P+YW-1:P]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= DEGREE; i++) begin
                r_w[i] <= (sum_ab[i] > (YW+1)'(ONE)) ? ONE : sum_ab[i][WW-1:0];
            end
            r_usc <= r_usb;
            r_fc  <= r_fb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    assign o_valid = r_vc;
    assign o_us    = r_usc;
    assign o_flags = r_fc;
    assign o_w     = r_w;

endmodule

`default_nettype wire

@@ hdl/bspline_basis_eval_core.sv @@
// B-spline basis evaluator (clamped uniform knots): top level with pipeline and
// result serializer. Depends on bbe_pkg and bbe_round.
//
// Usage:
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets the last control
//   index n; write it only while the block is idle. Reset value is 3.
//   Input channel (i_in_valid / o_in_stall) takes one curve parameter word in
//   unsigned Q1.FRACTION_BITS. Output channel (o_out_valid / i_out_stall) gives
//   DEGREE+1 words per parameter: control index, basis weight, last_of_run flag.
//   Path from input accept to the first result word: one span multiply stage,
//   three stages per recurrence level, one output register.
//   Throughput: one output word per cycle while i_out_stall is low, DEGREE+1 words
//   per parameter; new input words are taken each cycle while o_in_stall is low.
//   Reset clears every valid bit and the serializer; no clearing pass.
//   A stall on the output holds the output word and freezes the whole pipeline
//   once a finished item has nowhere to go, and o_in_stall rises at that point.
`default_nettype none

module bspline_basis_eval_core #(
    parameter int DEGREE        = 3,
    parameter int MAX_CONTROLS  = 64,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bbe_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [FRACTION_BITS:0]      i_curve_param,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [bbe_pkg::IDX_W-1:0]        o_control_index,
    output logic [FRACTION_BITS:0]           o_basis_weight,
    output logic                             o_last_of_run
);
    import bbe_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int UW    = F + SPAN_W;
    localparam int WW    = F + 1;
    localparam int CNT_W = (DEGREE + 1 > 1) ? $clog2(DEGREE + 1) : 1;
    localparam logic [WW-1:0] ONE = {1'b1, {F{1'b0}}};

    logic [CFG_W-1:0]  r_cfg;
    logic [CFG_W-1:0]  ctl_last;
    logic [SPAN_W-1:0] spans;

    logic                    pipe_en;
    logic                    ser_free;
    logic                    ser_load;

    logic                    vld_c   [DEGREE+1];
    logic [UW-1:0]           us_c    [DEGREE+1];
    t_flags                  flags_c [DEGREE+1];
    logic [DEGREE:0][WW-1:0] w_c     [DEGREE+1];

    logic                    r0_valid;
    logic [UW-1:0]           r0_us;
    t_flags                  r0_flags;

    logic                    r_ser_valid;
    logic [CNT_W-1:0]        r_cnt;
    logic [DEGREE:0][WW-1:0] r_ser_w;
    logic [IDX_W-1:0]        r_ser_base;
    logic [DEGREE:0][WW-1:0] n_ser_w;
    logic [IDX_W-1:0]        n_ser_base;
    logic                    cnt_last;

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_comb begin
        ctl_last = r_cfg;
        if (r_cfg < CFG_W'(DEGREE)) begin
            ctl_last = CFG_W'(DEGREE);
        end
        if (32'(ctl_last) > 32'(MAX_CONTROLS - 1)) begin
            ctl_last = CFG_W'(MAX_CONTROLS - 1);
        end
        spans = SPAN_W'(ctl_last) - SPAN_W'(DEGREE) + SPAN_W'(1);
    end

    // whole pipeline moves together; the serializer is the only sink
    assign cnt_last = (r_cnt == CNT_W'(DEGREE));
    assign ser_free = !r_ser_valid || (cnt_last && !i_out_stall);
    assign pipe_en  = !vld_c[DEGREE] || ser_free;
    assign ser_load = vld_c[DEGREE] && ser_free;
    assign o_in_stall = !pipe_en;

    // stage 0: u * spans
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r0_us            <= UW'(i_curve_param[F-1:0] * spans);
            r0_flags.is_zero <= (i_curve_param == '0);
            r0_flags.is_one  <= i_curve_param[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (pipe_en) begin
            r0_valid <= i_in_valid;
        end
    end

    always_comb begin
        vld_c[0]   = r0_valid;
        us_c[0]    = r0_us;
        flags_c[0] = r0_flags;
        w_c[0]     = '0;
        w_c[0][DEGREE] = ONE;
    end

    for (genvar d = 1; d <= DEGREE; d++) begin : g_round
        bbe_round #(
            .DEGREE        (DEGREE),
            .FRACTION_BITS (FRACTION_BITS),
            .ROUND         (d)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_spans (spans),
            .i_valid (vld_c[d-1]),
            .i_us    (us_c[d-1]),
            .i_flags (flags_c[d-1]),
            .i_w     (w_c[d-1]),
            .o_valid (vld_c[d]),
            .o_us    (us_c[d]),
            .o_flags (flags_c[d]),
            .o_w     (w_c[d])
        );
    end

    // end cases override the recurrence
    always_comb begin
        n_ser_w    = w_c[DEGREE];
        n_ser_base = IDX_W'(us_c[DEGREE][UW-1:F]);
        if (flags_c[DEGREE].is_one) begin
            n_ser_w         = '0;
            n_ser_w[DEGREE] = ONE;
            n_ser_base      = IDX_W'(ctl_last) - IDX_W'(DEGREE);
        end else if (flags_c[DEGREE].is_zero) begin
            n_ser_w    = '0;
            n_ser_w[0] = ONE;
            n_ser_base = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_ser_w    <= n_ser_w;
            r_ser_base <= n_ser_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (ser_load) begin
            r_ser_valid <= 1'b1;
            r_cnt       <= '0;
        end else if (r_ser_valid && !i_out_stall) begin
            if (cnt_last) begin
                r_ser_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_out_valid     = r_ser_valid;
    assign o_control_index = r_ser_base + IDX_W'(r_cnt);
    assign o_basis_weight  = r_ser_w[r_cnt];
    assign o_last_of_run   = cnt_last;

endmodule

`default_nettype wire

@@ hdl/bbe_checker.sv @@
// Port-level checker for the basis evaluator, bound to the top level.
// Depends on bbe_pkg and bspline_basis_eval_core_defines.svh.
`default_nettype none
`include "bspline_basis_eval_core_defines.svh"

module bbe_checker #(
    parameter int DEGREE        = 3,
    parameter int FRACTION_BITS = 16
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [bbe_pkg::IDX_W-1:0] o_control_index,
    input wire logic [FRACTION_BITS:0]    o_basis_weight,
    input wire logic                      o_last_of_run
);
    import bbe_pkg::*;

    localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    `BBE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "output word dropped under stall")
    `BBE_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_control_index) && $stable(o_basis_weight) && $stable(o_last_of_run), "stalled output word changed")
    `BBE_ASSERT_NEXT(a_run_step, o_out_valid && !i_out_stall && !o_last_of_run, o_out_valid && (o_control_index == IDX_W'($past(o_control_index) + IDX_W'(1))), "run broken or index not consecutive")
    `BBE_ASSERT_SAME(a_weight_max, o_out_valid, o_basis_weight <= ONE, "weight above one")
    `BBE_ASSERT_SAME(a_last_index, o_out_valid && o_last_of_run, o_control_index >= IDX_W'(DEGREE), "last word index below degree")

endmodule

bind bspline_basis_eval_core bbe_checker #(
    .DEGREE        (DEGREE),
    .FRACTION_BITS (FRACTION_BITS)
) u_bbe_checker (.*);

`default_nettype wire
